// File: design/wrsd_pkg.sv
// ----------------------------------------------------------------------------
// wrsd_pkg
// shared types and constants of the window range stationarity detector
// ----------------------------------------------------------------------------
package wrsd_pkg;

    localparam int DATA_W    = 32;
    localparam int HW_W      = 32;
    localparam int THR_W     = 33;
    localparam int LEN_CFG_W = 10;
    localparam int LEN_RESET = 300;

    localparam logic [THR_W-1:0]         THR_RESET  = 33'd2;
    localparam logic [HW_W-1:0]          USER_RESET = 32'd0;
    localparam logic [HW_W-1:0]          MINW_RESET = 32'd1;
    localparam logic signed [DATA_W-1:0] SMP_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SMP_MIN    = 32'sh8000_0000;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_WINDOW_LEN = 2'd0;
    localparam logic [1:0] CFG_USER_HW    = 2'd1;
    localparam logic [1:0] CFG_MIN_HW     = 2'd2;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CAL   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_UNKNOWN = 2'd0,
        MODE_STAT    = 2'd1,
        MODE_NONSTAT = 2'd2
    } t_mode;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_RANGE = 6'b000100,
        S_JUDGE = 6'b001000,
        S_CAL   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

endpackage

// File: design/wrsd_ram.sv
// ----------------------------------------------------------------------------
// wrsd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module wrsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/window_range_stationarity_detector.sv
// ----------------------------------------------------------------------------
// window_range_stationarity_detector
// sliding window min/max range tracker with a calibrated stationarity test
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_stall) carries a command and a sample:
//   add sample, calibrate threshold or clear window. every input transfer
//   yields exactly one result transfer on the output channel
//   (o_out_valid / i_out_stall): mode, mode_changed and accepted.
//   configuration writes (i_cfg_valid / o_cfg_ready) set the window length,
//   the user half-width and the minimum half-width; a window length write
//   also empties the window. writes are taken only while nothing is in
//   flight and no input transfer is offered
// command paths
//   clear, unused command, calibrate with window not full: straight to emit
//   add without rescan: range, judge, emit; calibrate with full window:
//   range, judge, cal, emit. an add that overwrites the slot holding the
//   min or max first rescans the valid slots; the rescan reads the window
//   memory one entry per cycle through its single read port
//   one item is worked on at a time; the next is taken once its result sits
//   in the output register
// reset and stall
//   synchronous active-low reset empties the window and restores register
//   defaults (length 300 clamped to the depth, half-widths 0 and 1)
//   the window memory holds no reset; only slots written since the last
//   clear are ever read. a stalled result holds, and the block waits for it
// ----------------------------------------------------------------------------
module window_range_stationarity_detector
    import wrsd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_cmd,
    input  logic signed [DATA_W-1:0] i_sample,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_mode,
    output logic                     o_mode_changed,
    output logic                     o_accepted,
    // configuration port
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data
);

    localparam int AW      = $clog2(WINDOW_DEPTH);
    localparam int LW      = $clog2(WINDOW_DEPTH + 1);
    localparam int LEN_RST = (LEN_RESET > WINDOW_DEPTH) ? WINDOW_DEPTH : LEN_RESET;

    // control state
    t_state                   r_state, n_state;
    logic [LW-1:0]            r_len, n_len;
    logic [HW_W-1:0]          r_user, n_user;
    logic [HW_W-1:0]          r_minw, n_minw;
    logic [AW-1:0]            r_wp, n_wp;
    logic                     r_full, n_full;
    logic signed [DATA_W-1:0] r_low, n_low;
    logic signed [DATA_W-1:0] r_high, n_high;
    logic [AW-1:0]            r_lpos, n_lpos;
    logic [AW-1:0]            r_hpos, n_hpos;
    logic                     r_judge, n_judge;
    logic [THR_W-1:0]         r_thr, n_thr;
    t_mode                    r_cur_mode, n_cur_mode;
    logic                     r_rd_valid, n_rd_valid;
    logic                     r_out_valid, n_out_valid;

    // working registers
    logic                     r_is_cal, n_is_cal;
    logic [LW-1:0]            r_scan_cnt, n_scan_cnt;
    logic [LW-1:0]            r_idx, n_idx;
    logic [AW-1:0]            r_rd_pos, n_rd_pos;
    logic [HW_W-1:0]          r_range, n_range;
    logic [HW_W-1:0]          r_hw, n_hw;
    t_mode                    r_res_mode, n_res_mode;
    logic                     r_res_changed, n_res_changed;
    logic                     r_res_acc, n_res_acc;
    t_mode                    r_out_mode, n_out_mode;
    logic                     r_out_changed, n_out_changed;
    logic                     r_out_acc, n_out_acc;

    // memory port
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic signed [DATA_W-1:0] ram_rdata;

    logic                     in_xfer;
    logic                     cfg_xfer;
    logic                     do_clear;
    logic [AW-1:0]            wp_eff;
    logic [LW-1:0]            wp_inc;
    logic                     wp_wrap;
    logic                     slot_hit;
    logic [LEN_CFG_W-1:0]     cfg_len;
    logic [LW-1:0]            cfg_len_clamped;
    logic [HW_W-1:0]          hw_final;
    t_mode                    judged;

    assign in_xfer     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    // an offered input goes first, so a write never lands beside an item
    assign o_cfg_ready = (r_state == S_IDLE) && !r_out_valid && !i_in_valid;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    // write position, wrapped if it ever sits past the length
    assign wp_eff   = (LW'(r_wp) >= r_len) ? '0 : r_wp;
    assign wp_inc   = LW'(wp_eff) + LW'(1);
    assign wp_wrap  = (wp_inc >= r_len);
    assign slot_hit = (wp_eff == r_lpos) || (wp_eff == r_hpos);

    // window length clamp to 1..depth
    assign cfg_len = i_cfg_data[LEN_CFG_W-1:0];
    always_comb begin
        if (cfg_len == '0) begin
            cfg_len_clamped = LW'(1);
        end else if (32'(cfg_len) > 32'(WINDOW_DEPTH)) begin
            cfg_len_clamped = LW'(WINDOW_DEPTH);
        end else begin
            cfg_len_clamped = LW'(cfg_len);
        end
    end

    assign hw_final = (r_minw > r_hw) ? r_minw : r_hw;

    always_comb begin
        if (r_full && r_judge) begin
            judged = ({1'b0, r_range} > r_thr) ? MODE_NONSTAT : MODE_STAT;
        end else begin
            judged = MODE_UNKNOWN;
        end
    end

    assign ram_waddr = wp_eff;
    assign ram_raddr = r_idx[AW-1:0];

    always_comb begin
        n_state       = r_state;
        n_len         = r_len;
        n_user        = r_user;
        n_minw        = r_minw;
        n_wp          = r_wp;
        n_full        = r_full;
        n_low         = r_low;
        n_high        = r_high;
        n_lpos        = r_lpos;
        n_hpos        = r_hpos;
        n_judge       = r_judge;
        n_thr         = r_thr;
        n_cur_mode    = r_cur_mode;
        n_rd_valid    = r_rd_valid;
        n_out_valid   = r_out_valid;
        n_is_cal      = r_is_cal;
        n_scan_cnt    = r_scan_cnt;
        n_idx         = r_idx;
        n_rd_pos      = r_rd_pos;
        n_range       = r_range;
        n_hw          = r_hw;
        n_res_mode    = r_res_mode;
        n_res_changed = r_res_changed;
        n_res_acc     = r_res_acc;
        n_out_mode    = r_out_mode;
        n_out_changed = r_out_changed;
        n_out_acc     = r_out_acc;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        do_clear      = 1'b0;

        // output register drains on transfer
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_cmd)
                        CMD_ADD: begin
                            ram_we   = 1'b1;
                            n_is_cal = 1'b0;
                            n_wp     = wp_wrap ? '0 : wp_inc[AW-1:0];
                            n_full   = r_full || wp_wrap;
                            if (slot_hit) begin
                                // an extreme is evicted, rescan the valid slots
                                n_scan_cnt = r_full ? r_len : wp_inc;
                                n_idx      = '0;
                                n_rd_valid = 1'b0;
                                n_state    = S_SCAN;
                            end else begin
                                if (i_sample < r_low) begin
                                    n_low  = i_sample;
                                    n_lpos = wp_eff;
                                end
                                if (i_sample > r_high) begin
                                    n_high = i_sample;
                                    n_hpos = wp_eff;
                                end
                                n_state = S_RANGE;
                            end
                        end
                        CMD_CAL: begin
                            if (r_full) begin
                                n_is_cal = 1'b1;
                                n_state  = S_RANGE;
                            end else begin
                                n_res_mode    = r_cur_mode;
                                n_res_changed = 1'b0;
                                n_res_acc     = 1'b0;
                                n_state       = S_EMIT;
                            end
                        end
                        CMD_CLEAR: begin
                            do_clear      = 1'b1;
                            n_res_mode    = MODE_UNKNOWN;
                            n_res_changed = 1'b0;
                            n_res_acc     = 1'b1;
                            n_state       = S_EMIT;
                        end
                        default: begin
                            n_res_mode    = r_cur_mode;
                            n_res_changed = 1'b0;
                            n_res_acc     = 1'b0;
                            n_state       = S_EMIT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // fold in the entry read last cycle
                if (r_rd_valid) begin
                    if (r_rd_pos == '0) begin
                        n_low  = ram_rdata;
                        n_high = ram_rdata;
                        n_lpos = '0;
                        n_hpos = '0;
                    end else begin
                        if (ram_rdata < r_low) begin
                            n_low  = ram_rdata;
                            n_lpos = r_rd_pos;
                        end
                        if (ram_rdata > r_high) begin
                            n_high = ram_rdata;
                            n_hpos = r_rd_pos;
                        end
                    end
                end
                if (r_idx < r_scan_cnt) begin
                    ram_re     = 1'b1;
                    n_rd_valid = 1'b1;
                    n_rd_pos   = r_idx[AW-1:0];
                    n_idx      = r_idx + LW'(1);
                end else begin
                    n_rd_valid = 1'b0;
                    n_state    = S_RANGE;
                end
            end
            S_RANGE: begin
                n_range = HW_W'(r_high - r_low);
                n_state = S_JUDGE;
            end
            S_JUDGE: begin
                if (r_is_cal) begin
                    n_hw    = (r_user > r_range) ? r_user : r_range;
                    n_state = S_CAL;
                end else begin
                    n_res_mode    = judged;
                    n_res_changed = (judged != r_cur_mode);
                    n_res_acc     = 1'b1;
                    n_cur_mode    = judged;
                    n_state       = S_EMIT;
                end
            end
            S_CAL: begin
                n_thr         = {hw_final, 1'b0};
                n_judge       = 1'b1;
                n_res_mode    = r_cur_mode;
                n_res_changed = 1'b0;
                n_res_acc     = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_mode    = r_res_mode;
                    n_out_changed = r_res_changed;
                    n_out_acc     = r_res_acc;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // configuration writes
        if (cfg_xfer) begin
            case (i_cfg_index)
                CFG_WINDOW_LEN: begin
                    n_len    = cfg_len_clamped;
                    do_clear = 1'b1;
                end
                CFG_USER_HW: begin
                    n_user = i_cfg_data;
                end
                CFG_MIN_HW: begin
                    n_minw = i_cfg_data;
                end
                default: begin
                    n_len = r_len;
                end
            endcase
        end

        // empty window, judgement off
        if (do_clear) begin
            n_full     = 1'b0;
            n_judge    = 1'b0;
            n_wp       = '0;
            n_lpos     = '0;
            n_hpos     = '0;
            n_cur_mode = MODE_UNKNOWN;
            n_low      = SMP_MAX;
            n_high     = SMP_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= LW'(LEN_RST);
            r_user      <= USER_RESET;
            r_minw      <= MINW_RESET;
            r_wp        <= '0;
            r_full      <= 1'b0;
            r_low       <= SMP_MAX;
            r_high      <= SMP_MIN;
            r_lpos      <= '0;
            r_hpos      <= '0;
            r_judge     <= 1'b0;
            r_thr       <= THR_RESET;
            r_cur_mode  <= MODE_UNKNOWN;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_user      <= n_user;
            r_minw      <= n_minw;
            r_wp        <= n_wp;
            r_full      <= n_full;
            r_low       <= n_low;
            r_high      <= n_high;
            r_lpos      <= n_lpos;
            r_hpos      <= n_hpos;
            r_judge     <= n_judge;
            r_thr       <= n_thr;
            r_cur_mode  <= n_cur_mode;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_cal      <= n_is_cal;
        r_scan_cnt    <= n_scan_cnt;
        r_idx         <= n_idx;
        r_rd_pos      <= n_rd_pos;
        r_range       <= n_range;
        r_hw          <= n_hw;
        r_res_mode    <= n_res_mode;
        r_res_changed <= n_res_changed;
        r_res_acc     <= n_res_acc;
        r_out_mode    <= n_out_mode;
        r_out_changed <= n_out_changed;
        r_out_acc     <= n_out_acc;
    end

    // window sample memory
    wrsd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (i_sample),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign o_out_valid    = r_out_valid;
    assign o_mode         = r_out_mode;
    assign o_mode_changed = r_out_changed;
    assign o_accepted     = r_out_acc;

endmodule

// File: design/wrsd_checker.sv
// ----------------------------------------------------------------------------
// wrsd_checker
// port-level checks of the window range stationarity detector
// ----------------------------------------------------------------------------
module wrsd_checker
    import wrsd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [1:0]        i_cmd,
    input logic [DATA_W-1:0] i_sample,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [1:0]        o_mode,
    input logic              o_mode_changed,
    input logic              o_accepted,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [1:0]        i_cfg_index,
    input logic [DATA_W-1:0] i_cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_mode) && $stable(o_mode_changed) && $stable(o_accepted))
        else $error("stalled result changed");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in flight");

    // a mode change is always a move into a judged mode
    a_change_judged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mode_changed |-> o_mode != MODE_UNKNOWN && o_accepted)
        else $error("mode change without a judged mode");

    // configuration only while nothing is pending
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_out_valid && !o_in_stall)
        else $error("configuration ready while busy");

endmodule

bind window_range_stationarity_detector wrsd_checker u_wrsd_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the window range stationarity detector: commands
// and samples go in through a bursty sender, every result is checked field
// by field against a behavioral copy of the window, extremes and threshold
// ----------------------------------------------------------------------------
module tb_top;
    import wrsd_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int WIN_DEPTH   = 512;
    localparam int TOTAL_ITEMS = 1150;
    // worst quiet stretch: a full 512-entry rescan plus a
    // receiver stall run and a sender gap; taken several times over
    localparam int QUIET_LIMIT = 4000;
    // tail after the last result: longer than the slowest single item
    localparam int TAIL_CYCLES = 600;

    // the command code the block has no meaning for
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        t_mode mode;
        logic  changed;
        logic  accepted;
    } t_verdict;

    // dut ports
    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [1:0]               i_cmd;
    logic signed [DATA_W-1:0] i_sample;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [1:0]               o_mode;
    logic                     o_mode_changed;
    logic                     o_accepted;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [1:0]               i_cfg_index;
    logic [DATA_W-1:0]        i_cfg_data;

    window_range_stationarity_detector #(
        .WINDOW_DEPTH(WIN_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_mode         (o_mode),
        .o_mode_changed (o_mode_changed),
        .o_accepted     (o_accepted),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // behavioral copy of the window state
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0] win_mem [0:WIN_DEPTH-1];
    int                       wr_pos;
    int                       lo_pos;
    int                       hi_pos;
    bit                       win_full;
    bit                       judge_on;
    logic signed [DATA_W-1:0] lo_val;
    logic signed [DATA_W-1:0] hi_val;
    logic [THR_W-1:0]         thr_w;
    t_mode                    held_mode;
    // register copies
    int                       win_len;
    logic [HW_W-1:0]          user_hw;
    logic [HW_W-1:0]          min_hw;

    // results still owed by the block, oldest first
    t_verdict pending_verdicts[$];

    int  items_sent;
    int  results_seen;
    int  fail_count;
    int  quiet_cycles;

    // idling controls
    bit  tx_gaps_on;
    bit  rx_stall_on;
    int  burst_left;
    int  stall_left;
    int  open_left;

    // length register: zero acts as one, anything past the depth as the depth
    function automatic int clamp_len(logic [LEN_CFG_W-1:0] v);
        if (v < 1) return 1;
        if (v > WIN_DEPTH) return WIN_DEPTH;
        return int'(v);
    endfunction

    function automatic void clear_window();
        win_full  = 1'b0;
        judge_on  = 1'b0;
        wr_pos    = 0;
        lo_pos    = 0;
        hi_pos    = 0;
        held_mode = MODE_UNKNOWN;
        lo_val    = SMP_MAX;
        hi_val    = SMP_MIN;
    endfunction

    // exact max - min, never negative once the window holds data
    function automatic logic [THR_W-1:0] cur_range();
        return {hi_val[DATA_W-1], hi_val} - {lo_val[DATA_W-1], lo_val};
    endfunction

    // full search of the first count slots; ties keep the lowest slot
    function automatic void rescan_extremes(int count);
        lo_val = win_mem[0];
        hi_val = win_mem[0];
        lo_pos = 0;
        hi_pos = 0;
        for (int i = 1; i < count && i < WIN_DEPTH; i++) begin
            if (win_mem[i] < lo_val) begin
                lo_val = win_mem[i];
                lo_pos = i;
            end
            if (win_mem[i] > hi_val) begin
                hi_val = win_mem[i];
                hi_pos = i;
            end
        end
    endfunction

    function automatic void apply_cfg(logic [1:0] idx, logic [DATA_W-1:0] data);
        case (idx)
            CFG_WINDOW_LEN: begin
                // a length write also empties the window
                win_len = clamp_len(data[LEN_CFG_W-1:0]);
                clear_window();
            end
            CFG_USER_HW: user_hw = data;
            CFG_MIN_HW:  min_hw = data;
            default: ;
        endcase
    endfunction

    // one accepted command in, the verdict it must produce out
    function automatic t_verdict window_judge(logic [1:0] cmd, logic signed [DATA_W-1:0] smp);
        t_verdict         v;
        int               wp;
        logic [THR_W-1:0] hw;
        t_mode            m;
        v.mode     = held_mode;
        v.changed  = 1'b0;
        v.accepted = 1'b1;
        case (cmd)
            CMD_ADD: begin
                wp = wr_pos;
                if (wp >= win_len) wp = 0;
                win_mem[wp] = smp;
                // overwriting a slot that held an extreme forces a rescan
                if (wp == lo_pos || wp == hi_pos) begin
                    rescan_extremes(win_full ? win_len : wp + 1);
                end else begin
                    if (smp < lo_val) begin
                        lo_val = smp;
                        lo_pos = wp;
                    end
                    if (smp > hi_val) begin
                        hi_val = smp;
                        hi_pos = wp;
                    end
                end
                wp++;
                if (wp >= win_len) begin
                    wp       = 0;
                    win_full = 1'b1;
                end
                wr_pos = wp;
                if (win_full && judge_on) begin
                    m = (cur_range() > thr_w) ? MODE_NONSTAT : MODE_STAT;
                end else begin
                    m = MODE_UNKNOWN;
                end
                v.changed = (m != held_mode);
                v.mode    = m;
                held_mode = m;
            end
            CMD_CAL: begin
                // held mode is reported as is, no re-judging
                if (win_full) begin
                    hw = cur_range();
                    if ({1'b0, user_hw} > hw) hw = {1'b0, user_hw};
                    if ({1'b0, min_hw} > hw) hw = {1'b0, min_hw};
                    thr_w    = hw << 1;
                    judge_on = 1'b1;
                end else begin
                    v.accepted = 1'b0;
                end
            end
            CMD_CLEAR: begin
                clear_window();
                v.mode = MODE_UNKNOWN;
            end
            default: v.accepted = 1'b0;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // failure bookkeeping: first ten reported in full, the rest counted
    // ------------------------------------------------------------------------
    task automatic note_failure(string what, t_verdict v);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] %s at result %0d: expected mode %0d changed %0d accepted %0d, got mode %0d changed %0d accepted %0d",
                     $time, what, results_seen, v.mode, v.changed, v.accepted,
                     o_mode, o_mode_changed, o_accepted);
        end
    endtask

    // ------------------------------------------------------------------------
    // result checker: every output transfer against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                v = '{MODE_UNKNOWN, 1'b0, 1'b0};
                note_failure("result with nothing pending", v);
            end else begin
                v = pending_verdicts.pop_front();
                if (o_mode !== v.mode || o_mode_changed !== v.changed
                        || o_accepted !== v.accepted) begin
                    note_failure("mismatch", v);
                end
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: any transfer on any channel resets the quiet count
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL window_range_stationarity_detector");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: alternating open and stalled runs of random length
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!rx_stall_on) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (open_left > 0) begin
            open_left--;
            i_out_stall <= 1'b0;
        end else begin
            stall_left = $urandom_range(0, 12);
            open_left  = $urandom_range(0, 20);
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // sender: one input transfer, predicted at the edge it is taken
    // ------------------------------------------------------------------------
    task automatic send_item(logic [1:0] cmd, logic signed [DATA_W-1:0] smp);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_sample   <= smp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_verdicts.push_back(window_judge(cmd, smp));
        items_sent++;
        // end of a burst: drop valid for a while, junk on the payload
        if (tx_gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                gap = $urandom_range(1, 8);
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                i_cmd      <= 2'($urandom_range(0, 3));
                i_sample   <= $urandom;
                repeat (gap - 1) @(negedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    // stop sending and wait for every owed result
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
    endtask

    // register write; callers make sure the block is idle first
    task automatic cfg_write(logic [1:0] idx, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_cfg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [HW_W-1:0] pick_half_width();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return $urandom_range(0, 255);
            default: return $urandom_range(0, 1 << 20);
        endcase
    endfunction

    // sample shapes: 0 full range, 1 noise around base, 2 rising ramp,
    // 3 falling ramp (rescans every sample once full), else flat with spikes
    function automatic logic signed [DATA_W-1:0] draw_sample(int shape, int idx,
            logic signed [DATA_W-1:0] base, int spread);
        int step;
        int off;
        step = spread / 16 + 1;
        off  = int'($urandom_range(0, spread)) - spread / 2;
        if ($urandom_range(0, 49) == 0) return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
        case (shape)
            0:       return $urandom;
            1:       return base + off;
            2:       return base + idx * step;
            3:       return base - idx * step;
            default: return (idx % 7 == 3) ? base + spread : base;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset configuration, window far from full: calibrate refused,
    // unused command ignored, extreme samples, clear
    task automatic test_idle_commands();
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        send_item(CMD_UNUSED, SMP_MAX);
        send_item(CMD_CAL, '0);
        send_item(CMD_ADD, SMP_MAX);
        send_item(CMD_ADD, SMP_MIN);
        send_item(CMD_CLEAR, '1);
    endtask

    // threshold corners on tiny windows, all back to back
    task automatic test_thresholds();
        drain_results();
        cfg_write(CFG_MIN_HW, '0);
        cfg_write(CFG_USER_HW, '0);
        // zero length acts as a single slot
        cfg_write(CFG_WINDOW_LEN, '0);
        send_item(CMD_ADD, 32'sd7);
        send_item(CMD_CAL, '0);
        send_item(CMD_ADD, 32'sd7);
        send_item(CMD_ADD, 32'sd8);
        drain_results();
        cfg_write(CFG_WINDOW_LEN, 32'd3);
        send_item(CMD_CAL, '0);
        // widest possible range, threshold at its top
        send_item(CMD_ADD, SMP_MIN);
        send_item(CMD_ADD, SMP_MAX);
        send_item(CMD_ADD, '0);
        send_item(CMD_CAL, '0);
        send_item(CMD_ADD, SMP_MIN);
        send_item(CMD_UNUSED, '0);
        send_item(CMD_CLEAR, '0);
        // equal samples: tied extremes, zero threshold, then a step of one
        send_item(CMD_ADD, 32'sd5);
        send_item(CMD_ADD, 32'sd5);
        send_item(CMD_ADD, 32'sd5);
        send_item(CMD_CAL, '0);
        send_item(CMD_ADD, 32'sd6);
        send_item(CMD_ADD, 32'sd6);
        send_item(CMD_ADD, 32'sd6);
        // half-width writes only count from the next calibrate on
        drain_results();
        cfg_write(CFG_USER_HW, '1);
        send_item(CMD_ADD, SMP_MAX);
        send_item(CMD_CAL, '0);
        send_item(CMD_ADD, SMP_MIN);
        drain_results();
        cfg_write(CFG_USER_HW, '0);
        cfg_write(CFG_MIN_HW, '1);
        send_item(CMD_CAL, '0);
    endtask

    // length register with every bit set: clamped to the full depth
    task automatic test_long_window();
        logic [DATA_W-1:0]        d;
        logic signed [DATA_W-1:0] base;
        drain_results();
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        d = $urandom;
        d[LEN_CFG_W-1:0] = '1;
        cfg_write(CFG_WINDOW_LEN, d);
        cfg_write(CFG_USER_HW, $urandom_range(0, 1 << 12));
        cfg_write(CFG_MIN_HW, 32'd1);
        base = $urandom;
        send_item(CMD_CAL, '0);
        for (int i = 0; i < win_len; i++) send_item(CMD_ADD, draw_sample(1, i, base, 1 << 13));
        send_item(CMD_CAL, '0);
        // widen the spread so the verdict flips
        for (int i = 0; i < 40; i++) begin
            send_item(CMD_ADD, draw_sample(1, i, base, (i < 20) ? (1 << 13) : (1 << 16)));
        end
    endtask

    // small windows, random shapes, mostly well formed: fill, calibrate,
    // keep streaming, with stray calibrates, clears and unused commands
    task automatic test_random_traffic();
        logic [DATA_W-1:0]        d;
        logic signed [DATA_W-1:0] base;
        int                       shape;
        int                       spread;
        int                       n;
        int                       pick;
        while (items_sent < TOTAL_ITEMS) begin
            // every phase starts from an idle block
            drain_results();
            tx_gaps_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7) begin
                d = $urandom;
                d[LEN_CFG_W-1:0] = ($urandom_range(0, 4) == 0)
                                   ? LEN_CFG_W'($urandom_range(0, 2))
                                   : LEN_CFG_W'($urandom_range(3, 40));
                cfg_write(CFG_WINDOW_LEN, d);
            end
            cfg_write(CFG_USER_HW, pick_half_width());
            if ($urandom_range(0, 1) == 1) cfg_write(CFG_MIN_HW, pick_half_width());
            shape  = $urandom_range(0, 4);
            base   = $urandom;
            spread = 1 << $urandom_range(0, 20);
            n      = win_len + $urandom_range(4, 2 * win_len + 8);
            // keep the whole run near the planned item count
            if (n > TOTAL_ITEMS - items_sent) n = TOTAL_ITEMS - items_sent;
            for (int i = 0; i < n; i++) begin
                if (i == n / 2) begin
                    spread = 1 << $urandom_range(0, 20);
                    // sometimes move the user bound while the window stays full
                    if ($urandom_range(0, 2) == 0) begin
                        drain_results();
                        cfg_write(CFG_USER_HW, pick_half_width());
                    end
                end
                pick = $urandom_range(0, 99);
                if (win_full && !judge_on && pick < 40) begin
                    send_item(CMD_CAL, $urandom);
                end else if (pick < 3) begin
                    send_item(CMD_CAL, $urandom);
                end else if (pick < 5) begin
                    send_item(CMD_CLEAR, $urandom);
                end else if (pick < 7) begin
                    send_item(CMD_UNUSED, $urandom);
                end else begin
                    send_item(CMD_ADD, draw_sample(shape, i, base, spread));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_cmd        = CMD_ADD;
        i_sample     = '0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_WINDOW_LEN;
        i_cfg_data   = '0;
        items_sent   = 0;
        results_seen = 0;
        fail_count   = 0;
        quiet_cycles = 0;
        tx_gaps_on   = 1'b0;
        rx_stall_on  = 1'b0;
        burst_left   = $urandom_range(1, 16);
        stall_left   = 0;
        open_left    = 0;

        // state after reset
        win_len = clamp_len(LEN_CFG_W'(LEN_RESET));
        user_hw = USER_RESET;
        min_hw  = MINW_RESET;
        thr_w   = THR_RESET;
        clear_window();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_commands();
        test_thresholds();
        test_long_window();
        test_random_traffic();

        drain_results();
        // catch anything that trails the last expected result
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_verdicts.size() == 0) begin
            $display("PASS window_range_stationarity_detector");
        end else begin
            $display("FAIL window_range_stationarity_detector");
        end
        $finish;
    end

endmodule

// File: sim.f
design/wrsd_pkg.sv
design/wrsd_ram.sv
design/window_range_stationarity_detector.sv
design/wrsd_checker.sv
test/tb_top.sv
